@@ design/hhf_pkg.sv @@
// Shared types and constants for the HTTP header framer.
// Holds the input, mode, event and error codes and the result record.
// No dependencies; every other file of the block imports it.
package hhf_pkg;

  // Input operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_ARM  = 2'd1,
    OP_STOP = 2'd2
  } op_e;

  // Receive mode of the framer.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_HDR     = 2'd1,
    MODE_BODY    = 2'd2,
    MODE_GETTAIL = 2'd3
  } mode_e;

  // Result event codes carried on the output tuser.
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_HBYTE = 3'd1,
    EV_LINE  = 3'd2,
    EV_RESP  = 3'd3,
    EV_REQ   = 3'd4,
    EV_BODY  = 3'd5,
    EV_ERR   = 3'd6
  } event_e;

  // Error codes reported with an error event.
  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_HDRS    = 3'd1,
    ERR_LINE    = 3'd2,
    ERR_FIRST   = 3'd3,
    ERR_GETBODY = 3'd4,
    ERR_IDLE    = 3'd5
  } err_e;

  // One result item as it moves from the core to the output queue.
  typedef struct packed {
    event_e     ev;
    err_e       code;
    logic [7:0] data;
    logic       last;
  } result_t;

  localparam result_t RESULT_NONE = '{ev: EV_NONE, code: ERR_NONE, data: 8'h00, last: 1'b0};

  // Configuration register indexes.
  localparam logic CFG_MAX_HEADERS = 1'b0;
  localparam logic CFG_MAX_LINE    = 1'b1;

  // Register reset values before truncation to the configured length width.
  localparam int unsigned RST_MAX_HEADERS = 2048;
  localparam int unsigned RST_MAX_LINE    = 1024;

  // Characters and first-line tags.
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [31:0] TAG_HTTP   = 32'h4854_5450;
  localparam logic [23:0] TAG_GET    = 24'h47_4554;
  localparam logic [2:0]  PREFIX_LEN = 3'd4;

endpackage

@@ design/hhf_core.sv @@
// Framing state and the per-byte update logic of the HTTP header framer.
// Works on the registered input item and yields up to two results.
// Depends on hhf_pkg.
module hhf_core #(
  parameter int LENGTH_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [1:0]             op_i,
  input  logic [7:0]             byte_i,
  input  logic                   pend_i,
  input  logic [LENGTH_BITS-1:0] max_hdr_i,
  input  logic [LENGTH_BITS-1:0] max_line_i,
  output logic [1:0]             count_o,
  output hhf_pkg::result_t       res0_o,
  output hhf_pkg::result_t       res1_o
);
  import hhf_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LINE_MAX  = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS:0]   TOTAL_MAX = {(LENGTH_BITS + 1){1'b1}};

  mode_e                  mode_q, mode_d;
  logic                   cr_q, cr_d;
  logic [LENGTH_BITS-1:0] line_q, line_d;
  logic [LENGTH_BITS:0]   total_q, total_d;
  logic                   first_q, first_d;
  logic [31:0]            pb_q, pb_d;
  logic [2:0]             pc_q, pc_d;

  logic [LENGTH_BITS-1:0] len1, len2;
  logic                   pupd1, pupd2;
  logic [31:0]            pb1, pb2;
  logic [2:0]             pc1, pc2;
  logic [LENGTH_BITS+1:0] sum_w;
  logic [LENGTH_BITS:0]   total_sat;
  logic                   http_ok, get_ok;
  logic [LENGTH_BITS:0]   line_chk;
  logic [1:0]             n;
  result_t                r0, r1;

  // A held CR becomes content first, then the new byte does.
  assign len1  = (cr_q && line_q != LINE_MAX) ? line_q + 1'b1 : line_q;
  assign pupd1 = cr_q && !first_q && (pc_q < PREFIX_LEN);
  assign pb1   = pupd1 ? {pb_q[23:0], CH_CR} : pb_q;
  assign pc1   = pupd1 ? pc_q + 3'd1 : pc_q;

  assign len2  = (len1 != LINE_MAX) ? len1 + 1'b1 : len1;
  assign pupd2 = !first_q && (pc1 < PREFIX_LEN);
  assign pb2   = pupd2 ? {pb1[23:0], byte_i} : pb1;
  assign pc2   = pupd2 ? pc1 + 3'd1 : pc1;

  // Completed line added to the running total, saturating at all ones.
  assign sum_w     = {1'b0, total_q} + {2'b00, line_q};
  assign total_sat = sum_w[LENGTH_BITS+1] ? TOTAL_MAX : sum_w[LENGTH_BITS:0];

  // First-line sorting on the empty line.
  assign http_ok = first_q && (pc_q >= PREFIX_LEN) && (pb_q == TAG_HTTP);
  assign get_ok  = first_q && (((pc_q == 3'd3) && (pb_q == {8'h00, TAG_GET})) ||
                               ((pc_q >= PREFIX_LEN) && (pb_q[31:8] == TAG_GET)));

  // Partial line length after this byte, a newly held CR included.
  assign line_chk = (byte_i == CH_CR) ? ({1'b0, len1} + {{LENGTH_BITS{1'b0}}, 1'b1})
                                      : {1'b0, len2};

  // Next state and results for the item in the input register.
  always_comb begin
    mode_d  = mode_q;
    cr_d    = cr_q;
    line_d  = line_q;
    total_d = total_q;
    first_d = first_q;
    pb_d    = pb_q;
    pc_d    = pc_q;
    n       = 2'd0;
    r0      = RESULT_NONE;
    r1      = RESULT_NONE;
    case (op_i)
      OP_ARM, OP_STOP: begin
        cr_d    = 1'b0;
        line_d  = '0;
        total_d = '0;
        first_d = 1'b0;
        pb_d    = '0;
        pc_d    = '0;
        mode_d  = (op_i == OP_ARM) ? MODE_HDR : MODE_IDLE;
      end
      OP_DATA: begin
        case (mode_q)
          MODE_HDR: begin
            if (byte_i == CH_LF) begin
              cr_d = 1'b0;
              n    = 2'd1;
              if (line_q != '0) begin
                total_d = total_sat;
                first_d = 1'b1;
                line_d  = '0;
                if (total_sat > {1'b0, max_hdr_i}) begin
                  mode_d  = MODE_IDLE;
                  r0.ev   = EV_ERR;
                  r0.code = ERR_HDRS;
                end else begin
                  r0.ev = EV_LINE;
                end
              end else if (http_ok) begin
                mode_d = MODE_BODY;
                r0.ev  = EV_RESP;
              end else if (get_ok) begin
                mode_d = pend_i ? MODE_IDLE : MODE_GETTAIL;
                r0.ev  = EV_REQ;
              end else begin
                mode_d  = MODE_IDLE;
                r0.ev   = EV_ERR;
                r0.code = ERR_FIRST;
              end
            end else begin
              if (byte_i == CH_CR) begin
                cr_d   = 1'b1;
                line_d = len1;
                pb_d   = pb1;
                pc_d   = pc1;
              end else begin
                cr_d   = 1'b0;
                line_d = len2;
                pb_d   = pb2;
                pc_d   = pc2;
              end
              // Content results: the held CR first, then the byte itself.
              if (cr_q) begin
                r0.ev   = EV_HBYTE;
                r0.data = CH_CR;
                if (byte_i != CH_CR) begin
                  r1.ev   = EV_HBYTE;
                  r1.data = byte_i;
                  n       = 2'd2;
                end else begin
                  n = 2'd1;
                end
              end else if (byte_i != CH_CR) begin
                r0.ev   = EV_HBYTE;
                r0.data = byte_i;
                n       = 2'd1;
              end
              // A partial line too long at packet end replaces those results.
              if (pend_i && (line_chk > {1'b0, max_line_i})) begin
                mode_d = MODE_IDLE;
                r0     = RESULT_NONE;
                r1     = RESULT_NONE;
                r0.ev   = EV_ERR;
                r0.code = ERR_LINE;
                n       = 2'd1;
              end
            end
          end
          MODE_BODY: begin
            r0.ev   = EV_BODY;
            r0.data = byte_i;
            n       = 2'd1;
          end
          MODE_GETTAIL: begin
            mode_d  = MODE_IDLE;
            r0.ev   = EV_ERR;
            r0.code = ERR_GETBODY;
            n       = 2'd1;
          end
          default: begin
            mode_d  = MODE_IDLE;
            r0.ev   = EV_ERR;
            r0.code = ERR_IDLE;
            n       = 2'd1;
          end
        endcase
      end
      default: begin
      end
    endcase
    // Mark the final result of the item.
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end else if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign count_o = n;
  assign res0_o  = r0;
  assign res1_o  = r1;

  // State registers, updated when the item is handed on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      cr_q    <= 1'b0;
      line_q  <= '0;
      total_q <= '0;
      first_q <= 1'b0;
      pb_q    <= '0;
      pc_q    <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      cr_q    <= cr_d;
      line_q  <= line_d;
      total_q <= total_d;
      first_q <= first_d;
      pb_q    <= pb_d;
      pc_q    <= pc_d;
    end
  end

endmodule

@@ design/hhf_out_buf.sv @@
// Two-slot result queue that drives the output stream of the framer.
// Takes up to two results per cycle and hands out one per transfer.
// Depends on hhf_pkg.
module hhf_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  hhf_pkg::result_t res0_i,
  input  hhf_pkg::result_t res1_i,
  input  logic             ready_i,
  output logic             valid_o,
  output hhf_pkg::result_t head_o,
  output logic [1:0]       space_o
);
  import hhf_pkg::*;

  result_t    slot0_q, slot0_d;
  result_t    slot1_q, slot1_d;
  logic [1:0] count_q, count_d;
  logic [1:0] count_mid;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot0_q;
  assign pop     = valid_o && ready_i;
  // Free slots once this cycle's transfer is taken into account.
  assign space_o = 2'd2 - count_q + {1'b0, pop};

  // Shift on a transfer, then append the new results behind what remains.
  always_comb begin
    slot0_d   = slot0_q;
    slot1_d   = slot1_q;
    count_mid = count_q;
    if (pop) begin
      slot0_d   = slot1_q;
      count_mid = count_q - 2'd1;
    end
    if (push_n_i != 2'd0) begin
      case (count_mid)
        2'd0: begin
          slot0_d = res0_i;
          slot1_d = res1_i;
        end
        2'd1: begin
          slot1_d = res0_i;
        end
        default: begin
        end
      endcase
    end
    count_d = count_mid + push_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

@@ design/http_header_framer.sv @@
// HTTP header framer, top level.
// Byte stream in on s_axis: tdata is the received byte, tuser the operation
// (data byte, arm and clear, force idle), tlast marks the last byte of a
// packet. Results leave on m_axis: tuser is the event code, tdata carries the
// error code and the header or body byte, tlast marks the final result of an
// input item. Limits are written through the cfg port (index 0 header total
// limit, index 1 partial line limit); the user must write them only while
// the block is idle, and the block itself does not enforce this.
// Throughput is one input item per cycle as long as each item gives at most
// one result and the receiver does not stall; a CR passed on ahead of a
// following byte gives two results, handed out one per transfer. The two-slot
// output queue sets that figure. An accepted item waits in the input register
// until the queue has room; its results enter the queue, whose head drives m_axis.
// After reset the block is idle with the limits at 2048 and 1024 (truncated
// to LENGTH_BITS); data bytes are reported as errors until an arm operation.
// When the receiver stalls, the queue fills and s_axis_tready_o drops; no
// result is lost and the framing state stands still until space frees up.
// Depends on hhf_pkg, hhf_core and hhf_out_buf.
module http_header_framer #(
  parameter int LENGTH_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,  // data_byte[7:0]
  input  logic [1:0]             s_axis_tuser_i,  // op[1:0]
  input  logic                   s_axis_tlast_i,
  // Result stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [15:0]            m_axis_tdata_o,  // error_code[2:0], data_out[10:3], zero fill
  output logic [2:0]             m_axis_tuser_o,  // event_res[2:0]
  output logic                   m_axis_tlast_o,
  // Configuration writes.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [LENGTH_BITS-1:0] cfg_data_i
);
  import hhf_pkg::*;

  logic                   in_valid_q, in_valid_d;
  logic [1:0]             in_op_q;
  logic [7:0]             in_byte_q;
  logic                   in_last_q;
  logic [LENGTH_BITS-1:0] max_hdr_q, max_line_q;
  logic                   s_accept;
  logic                   advance;
  logic [1:0]             core_n;
  logic [1:0]             space;
  result_t                res0, res1, head;

  // The registered item moves on when the queue has room for its results.
  assign advance         = in_valid_q && (core_n <= space);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q   <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Configuration registers; every write transfer is taken at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_hdr_q  <= LENGTH_BITS'(RST_MAX_HEADERS);
      max_line_q <= LENGTH_BITS'(RST_MAX_LINE);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_MAX_HEADERS) begin
        max_hdr_q <= cfg_data_i;
      end else begin
        max_line_q <= cfg_data_i;
      end
    end
  end

  hhf_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .op_i      (in_op_q),
    .byte_i    (in_byte_q),
    .pend_i    (in_last_q),
    .max_hdr_i (max_hdr_q),
    .max_line_i(max_line_q),
    .count_o   (core_n),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  hhf_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_n_i(advance ? core_n : 2'd0),
    .res0_i  (res0),
    .res1_i  (res1),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head),
    .space_o (space)
  );

  // Output packing.
  assign m_axis_tdata_o = {5'b00000, head.data, head.code};
  assign m_axis_tuser_o = head.ev;
  assign m_axis_tlast_o = head.last;

endmodule

@@ design/hhf_checker.sv @@
// Port-level checks for the HTTP header framer, attached by bind.
// Watches the result stream for consistency of event, code, data and tlast.
// Depends on hhf_pkg and the http_header_framer ports.
module hhf_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import hhf_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // An error event carries a code, and only an error event does.
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tuser_o == EV_ERR) == (m_axis_tdata_o[2:0] != ERR_NONE)))
    else $error("error code does not match event");

  // Only header and body bytes carry a data byte.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != EV_HBYTE && m_axis_tuser_o != EV_BODY)
      |-> (m_axis_tdata_o[10:3] == 8'h00))
    else $error("data byte on a control event");

  // Every event but a header byte is the only result of its item.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != EV_HBYTE) |-> m_axis_tlast_o)
    else $error("tlast missing on a single-result event");

  // No empty result is ever offered.
  a_no_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != EV_NONE))
    else $error("empty result offered");

endmodule

bind http_header_framer hhf_port_checker u_hhf_checker (.*);

@@ verif/hhf_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the HTTP header framer testbench.
// Watches the byte, result and configuration channels, predicts the results
// of each byte transfer and compares them in order. Imports hhf_pkg.
module hhf_checker #(
  parameter int LENGTH_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Byte stream into the framer.
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [7:0]             s_axis_tdata_i,  // data_byte[7:0]
  input  logic [1:0]             s_axis_tuser_i,  // op[1:0]
  input  logic                   s_axis_tlast_i,
  // Result stream out of the framer.
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [15:0]            m_axis_tdata_i,  // error_code[2:0], data_out[10:3], zero fill
  input  logic [2:0]             m_axis_tuser_i,  // event_res[2:0]
  input  logic                   m_axis_tlast_i,
  // Configuration writes.
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic                   cfg_index_i,
  input  logic [LENGTH_BITS-1:0] cfg_data_i,
  // Status for the testbench top.
  output int                     fail_count_o,
  output int                     pending_o
);
  import hhf_pkg::*;

  localparam int TOTAL_SAT = (1 << (LENGTH_BITS + 1)) - 1;

  // Limits as last written.
  logic [LENGTH_BITS-1:0] hdr_limit;
  logic [LENGTH_BITS-1:0] line_limit;

  // Framing state of the predictor.
  mode_e                  rx_mode;
  logic                   cr_held_q;
  logic [LENGTH_BITS-1:0] line_len;
  logic [LENGTH_BITS:0]   hdr_total;
  logic                   first_done;
  logic [31:0]            prefix_word;
  logic [2:0]             prefix_cnt;

  // Results of the byte being predicted, and all results still owed.
  result_t step_results[$];
  result_t framer_results_q[$];
  int      mismatches;

  function automatic void clear_header_state();
    cr_held_q   = 1'b0;
    line_len    = '0;
    hdr_total   = '0;
    first_done  = 1'b0;
    prefix_word = '0;
    prefix_cnt  = '0;
  endfunction

  function automatic void push_result(event_e ev, err_e code, logic [7:0] data);
    result_t r;
    r.ev   = ev;
    r.code = code;
    r.data = data;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  // An error replaces whatever the byte would have produced.
  function automatic void flag_error(err_e code);
    rx_mode = MODE_IDLE;
    step_results.delete();
    push_result(EV_ERR, code, 8'h00);
  endfunction

  // Count one content byte and collect the leading bytes of the first line.
  function automatic void take_content(logic [7:0] b);
    if (line_len != '1) line_len++;
    if (!first_done && prefix_cnt < PREFIX_LEN) begin
      prefix_word = {prefix_word[23:0], b};
      prefix_cnt++;
    end
  endfunction

  // A line feed closes a header line, or ends the headers on an empty line.
  function automatic void close_line(logic pend);
    int sum;
    cr_held_q = 1'b0;
    if (line_len != '0) begin
      sum = int'(hdr_total) + int'(line_len);
      if (sum > TOTAL_SAT) sum = TOTAL_SAT;
      hdr_total  = (LENGTH_BITS + 1)'(sum);
      first_done = 1'b1;
      line_len   = '0;
      if (int'(hdr_total) > int'(hdr_limit)) flag_error(ERR_HDRS);
      else push_result(EV_LINE, ERR_NONE, 8'h00);
      return;
    end
    if (first_done && prefix_cnt >= PREFIX_LEN && prefix_word == TAG_HTTP) begin
      rx_mode = MODE_BODY;
      push_result(EV_RESP, ERR_NONE, 8'h00);
    end else if (first_done &&
                 ((prefix_cnt == 3'd3 && prefix_word == {8'h00, TAG_GET}) ||
                  (prefix_cnt >= PREFIX_LEN && prefix_word[31:8] == TAG_GET))) begin
      // A request that ends its packet goes idle at once.
      rx_mode = pend ? MODE_IDLE : MODE_GETTAIL;
      push_result(EV_REQ, ERR_NONE, 8'h00);
    end else begin
      flag_error(ERR_FIRST);
    end
  endfunction

  function automatic void take_header_byte(logic [7:0] b, logic pend);
    if (b == CH_LF) begin
      close_line(pend);
      return;
    end
    // A held CR not followed by LF is plain content ahead of this byte.
    if (cr_held_q) begin
      take_content(CH_CR);
      push_result(EV_HBYTE, ERR_NONE, CH_CR);
      cr_held_q = 1'b0;
    end
    if (b == CH_CR) begin
      cr_held_q = 1'b1;
    end else begin
      take_content(b);
      push_result(EV_HBYTE, ERR_NONE, b);
    end
    if (pend && (int'(line_len) + int'(cr_held_q)) > int'(line_limit)) flag_error(ERR_LINE);
  endfunction

  // Work out the results of one byte transfer and queue them.
  function automatic void predict_step(logic [1:0] op, logic [7:0] b, logic pend);
    result_t r;
    step_results.delete();
    case (op)
      OP_ARM: begin
        clear_header_state();
        rx_mode = MODE_HDR;
      end
      OP_STOP: begin
        clear_header_state();
        rx_mode = MODE_IDLE;
      end
      OP_DATA: begin
        case (rx_mode)
          MODE_HDR:     take_header_byte(b, pend);
          MODE_BODY:    push_result(EV_BODY, ERR_NONE, b);
          MODE_GETTAIL: flag_error(ERR_GETBODY);
          default:      flag_error(ERR_IDLE);
        endcase
      end
      default: ;  // The reserved operation is ignored.
    endcase
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) framer_results_q.push_back(step_results[i]);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void compare_result();
    result_t want;
    if (framer_results_q.size() == 0) begin
      mismatches++;
      $display("%0t ns: expected no result, got event %0d", $time, m_axis_tuser_i);
      return;
    end
    want = framer_results_q.pop_front();
    check_field("event", {5'b0, want.ev}, {5'b0, m_axis_tuser_i});
    check_field("error code", {5'b0, want.code}, {5'b0, m_axis_tdata_i[2:0]});
    check_field("data", want.data, m_axis_tdata_i[10:3]);
    check_field("last", {7'b0, want.last}, {7'b0, m_axis_tlast_i});
  endfunction

  initial begin
    hdr_limit  = LENGTH_BITS'(RST_MAX_HEADERS);
    line_limit = LENGTH_BITS'(RST_MAX_LINE);
    rx_mode    = MODE_IDLE;
    mismatches = 0;
    clear_header_state();
  end

  // Follow every transfer on the three channels at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_MAX_HEADERS) hdr_limit = cfg_data_i;
        else line_limit = cfg_data_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_step(s_axis_tuser_i, s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) compare_result();
    end
    pending_o <= framer_results_q.size();
  end

  assign fail_count_o = mismatches;

endmodule

@@ verif/tb_http_header_framer.sv @@
`timescale 1ns / 1ps
// Testbench top for the HTTP header framer.
// Drives byte and configuration transfers and a stalling receiver; the
// hhf_checker instance predicts and compares. Depends on hhf_pkg and the RTL.
module tb_http_header_framer;
  import hhf_pkg::*;

  localparam int         LENGTH_BITS     = 12;
  localparam logic [1:0] OP_RSVD         = 2'd3;
  localparam int         CYCLE_LIMIT     = 1_000_000;
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         RANDOM_ITEMS    = 700;
  localparam int         NUM_PHASES      = 8;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [7:0]             s_axis_tdata_i  = 8'h00;
  logic [1:0]             s_axis_tuser_i  = OP_DATA;
  logic                   s_axis_tlast_i  = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [15:0]            m_axis_tdata_o;
  logic [2:0]             m_axis_tuser_o;
  logic                   m_axis_tlast_o;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_index_i     = CFG_MAX_HEADERS;
  logic [LENGTH_BITS-1:0] cfg_data_i      = '0;

  int fail_count;
  int pending_results;
  int cycle_cnt  = 0;
  int data_items = 0;
  int rx_hold    = 0;
  bit gaps_on    = 1'b0;
  bit stalls_on  = 1'b0;
  bit stray_on   = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  http_header_framer #(
    .LENGTH_BITS(LENGTH_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  hhf_checker #(
    .LENGTH_BITS(LENGTH_BITS)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .m_axis_tlast_i (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending_results)
  );

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Occasional packet end in the middle of the headers.
  function automatic logic stray_pend();
    return stray_on && ($urandom_range(0, 11) == 0);
  endfunction

  // Any header content byte; LF is swapped for CR to keep the line open.
  function automatic logic [7:0] content_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CH_LF) b = CH_CR;
    return b;
  endfunction

  // Receiver side: random stalls of random length.
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      rx_hold = idle_len() - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // One input transfer, optionally after an idle gap.
  task automatic send_item(logic [1:0] op, logic [7:0] b, logic last);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (op != OP_RSVD) data_items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_DATA, s[i], stray_pend());
  endtask

  task automatic send_bytes(int n);
    repeat (n) send_item(OP_DATA, content_byte(), stray_pend());
  endtask

  // Line end: CRLF most of the time, a bare LF otherwise.
  task automatic end_line(logic pend);
    if ($urandom_range(0, 9) < 7) send_item(OP_DATA, CH_CR, stray_pend());
    send_item(OP_DATA, CH_LF, pend);
  endtask

  // Only called with nothing in flight.
  task automatic set_limits(logic [LENGTH_BITS-1:0] hdr, logic [LENGTH_BITS-1:0] line);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MAX_HEADERS;
    cfg_data_i  <= hdr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_MAX_LINE;
    cfg_data_i  <= line;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold off the sender until every owed result is in, then let it settle.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One header block with random content: response, request or malformed.
  task automatic send_message();
    int   kind;
    int   n;
    logic is_get;
    if ($urandom_range(0, 9) != 0) send_item(OP_ARM, 8'($urandom), 1'($urandom));
    kind   = $urandom_range(0, 9);
    is_get = (kind >= 4 && kind <= 6);
    case (kind)
      0, 1:    send_text("HTTP/1.1 200 OK");
      2, 3:    send_text("HTTP");
      4, 5:    send_text("GET /index");
      6:       send_text("GET");
      7:       send_bytes($urandom_range(1, 8));
      8:       send_text("GE");
      default: ;  // Empty first line.
    endcase
    if (kind != 9) begin
      send_bytes($urandom_range(0, 3));
      end_line(stray_pend());
    end
    repeat ($urandom_range(0, 3)) begin
      send_text("X-");
      send_bytes($urandom_range(0, 10));
      end_line(stray_pend());
    end
    end_line(is_get ? 1'($urandom_range(0, 1)) : stray_pend());
    // Body bytes after a response, or a stray byte after a request.
    if (is_get) begin
      if ($urandom_range(0, 1) != 0) send_item(OP_DATA, 8'($urandom), 1'b1);
    end else begin
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) send_item(OP_DATA, 8'($urandom), i == n - 1);
    end
    if ($urandom_range(0, 3) == 0) send_item(OP_STOP, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
  endtask

  // Run timeout.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("http_header_framer: mismatch");
    $finish;
  end

  initial begin
    logic [LENGTH_BITS-1:0] hdr_lim;
    logic [LENGTH_BITS-1:0] line_lim;
    int                     start_items;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks at the reset limits.
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_item(OP_DATA, 8'h00, 1'b0);  // data while idle
    send_item(OP_RSVD, 8'hFF, 1'b1);  // reserved operation, ignored
    send_item(OP_ARM, 8'h00, 1'b0);
    send_item(OP_DATA, CH_LF, 1'b0);  // empty headers
    send_item(OP_ARM, 8'h00, 1'b0);
    send_text("GET");
    send_item(OP_DATA, CH_CR, 1'b0);
    send_item(OP_DATA, "x", 1'b0);    // held CR comes out ahead of this byte
    send_item(OP_DATA, CH_CR, 1'b0);
    send_item(OP_DATA, CH_LF, 1'b0);
    send_item(OP_DATA, CH_LF, 1'b0);  // request, packet still running
    send_item(OP_DATA, 8'hFF, 1'b0);  // body after a request
    send_item(OP_ARM, 8'hFF, 1'b1);
    send_text("HTTP");
    send_item(OP_DATA, CH_LF, 1'b0);
    send_item(OP_DATA, CH_LF, 1'b1);  // response
    send_item(OP_DATA, 8'hFF, 1'b0);
    send_item(OP_DATA, 8'h00, 1'b1);
    send_item(OP_STOP, 8'h00, 1'b0);
    send_item(OP_DATA, 8'h80, 1'b0);
    send_item(OP_ARM, 8'h00, 1'b0);
    send_text("GET");
    send_item(OP_DATA, CH_LF, 1'b0);
    send_item(OP_DATA, CH_LF, 1'b1);  // request ending its packet
    send_item(OP_DATA, 8'h01, 1'b0);
    wait_drained();

    // Random phases, each under its own limits.
    stray_on = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          hdr_lim  = '0;
          line_lim = '0;
        end
        1: begin
          hdr_lim  = '1;
          line_lim = '1;
        end
        2: begin
          hdr_lim  = LENGTH_BITS'(RST_MAX_HEADERS);
          line_lim = LENGTH_BITS'(RST_MAX_LINE);
        end
        3, 4: begin
          hdr_lim  = LENGTH_BITS'($urandom_range(0, 60));
          line_lim = LENGTH_BITS'($urandom_range(0, 12));
        end
        5: begin
          hdr_lim  = LENGTH_BITS'($urandom);
          line_lim = LENGTH_BITS'($urandom);
        end
        default: begin
          hdr_lim  = LENGTH_BITS'($urandom_range(20, 200));
          line_lim = LENGTH_BITS'($urandom_range(4, 40));
        end
      endcase
      gaps_on   = (p % 3 != 2);
      stalls_on = (p % 4 != 2);
      set_limits(hdr_lim, line_lim);
      start_items = data_items;
      while (data_items - start_items < RANDOM_ITEMS / NUM_PHASES) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_message();
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("http_header_framer: match");
    end else begin
      $display("http_header_framer: mismatch");
    end
    $finish;
  end

endmodule
